@@ hdl/i2sc_pkg.sv @@
package i2sc_pkg;

   localparam int RING_FRAMES_DEFAULT = 4;
   localparam int FRAME_MAX_DEFAULT   = 256;
   localparam int SLOT_BITS           = 32;
   localparam int PCM_BITS            = 16;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_INDEX_W         = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_SELECT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_BITS         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE_OFFSET    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_SAMPLES     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_DURATION_US = 3'd4;

   localparam logic        CMD_WORD = 1'b0;
   localparam logic        CMD_READ = 1'b1;

   localparam logic [5:0]  WORD_BITS_RESET      = 6'd24;
   localparam logic [10:0] FRAME_SAMPLES_RESET  = 11'd256;
   localparam logic [31:0] FRAME_DURATION_RESET = 32'd5333;

   typedef struct packed {
      logic               channel_select;
      logic [5:0]         word_bits;
      logic signed [5:0]  capture_offset;
      logic [10:0]        frame_samples;
      logic [31:0]        frame_duration_us;
   } cfg_type;

   typedef struct packed {
      logic                cmd;
      logic [PCM_BITS-1:0] sample;
      logic [63:0]         now_us;
   } item_type;

endpackage

@@ hdl/i2sc_if.sv @@
interface i2sc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] raw_word;
   logic [63:0] now_us;
   modport source (output valid, cmd, raw_word, now_us, input ready);
   modport sink (input valid, cmd, raw_word, now_us, output ready);
endinterface

interface i2sc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last_of_frame;
   logic               frame_ready;
   logic [63:0]        frame_start_index;
   logic [63:0]        block_count;
   logic [3:0]         ring_slot;
   logic [31:0]        dropped_before;
   logic [63:0]        block_end_us;
   logic [63:0]        block_start_us;
   modport source (output valid, sample, last_of_frame, frame_ready, frame_start_index,
                   block_count, ring_slot, dropped_before, block_end_us, block_start_us,
                   input ready);
   modport sink (input valid, sample, last_of_frame, frame_ready, frame_start_index,
                 block_count, ring_slot, dropped_before, block_end_us, block_start_us,
                 output ready);
endinterface

@@ hdl/i2sc_ram.sv @@
module i2sc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/i2sc_front.sv @@
module i2sc_front (
   input  logic                clock,
   input  logic                reset,
   input  i2sc_pkg::cfg_type   cfg,
   i2sc_req_if.sink            req_ch,
   output i2sc_pkg::item_type  head,
   output logic                head_valid,
   input  logic                pop
);
   import i2sc_pkg::*;

   logic [SLOT_BITS-1:0] shifted;
   logic [5:0]           neg_off;
   logic [5:0]           v_eff;
   logic [4:0]           low_zero;
   logic [PCM_BITS-1:0]  pcm;
   item_type             entry;
   item_type             q_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;

   // capture shift, then keep the top valid bits scaled to 16
   always_comb begin
      neg_off = 6'(-cfg.capture_offset);
      if (!cfg.capture_offset[5]) begin
         shifted = req_ch.raw_word << cfg.capture_offset[4:0];
      end else if (neg_off[5]) begin
         shifted = '0;
      end else begin
         shifted = req_ch.raw_word >> neg_off[4:0];
      end
      priority if (cfg.word_bits == 6'd0) begin
         v_eff = 6'd1;
      end else if (cfg.word_bits > 6'd32) begin
         v_eff = 6'd32;
      end else begin
         v_eff = cfg.word_bits;
      end
      low_zero = (v_eff >= 6'd16) ? 5'd0 : 5'(6'd16 - v_eff);
      pcm = shifted[31:16] & (16'hFFFF << low_zero);
   end

   assign entry.cmd    = req_ch.cmd;
   assign entry.sample = pcm;
   assign entry.now_us = req_ch.now_us;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign head         = q_ff[rd_ptr_ff];
   assign head_valid   = (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end
endmodule

@@ hdl/i2sc_back.sv @@
module i2sc_back #(
   parameter int RING_FRAMES = 4,
   parameter int FRAME_MAX   = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  i2sc_pkg::cfg_type   cfg,
   input  i2sc_pkg::item_type  head,
   input  logic                head_valid,
   output logic                pop,
   i2sc_rsp_if.source          rsp_ch
);
   import i2sc_pkg::*;

   localparam int SLOT_W = $clog2(RING_FRAMES);
   localparam int POS_W  = FRAME_MAX > 1 ? $clog2(FRAME_MAX) : 1;
   localparam int WPOS_W = $clog2(2 * FRAME_MAX + 1);
   localparam int FR_W   = $clog2(RING_FRAMES + 1);
   localparam int DEPTH  = RING_FRAMES * FRAME_MAX;
   localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WAIT = 1'b1;

   logic              state_ff, state_in;
   logic [SLOT_W-1:0] ws_ff, ws_in, rs_ff, rs_in, ws_next, rs_next;
   logic [FR_W-1:0]   fr_ff, fr_in;
   logic [31:0]       drop_total_ff, drop_total_in;
   logic [31:0]       drop_rep_ff, drop_rep_in;
   logic [31:0]       drop_lat_ff, drop_lat_in;
   logic [63:0]       next_start_ff, next_start_in;
   logic [63:0]       next_block_ff, next_block_in;
   logic [WPOS_W-1:0] wpos_ff, wpos_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in;

   logic [63:0] meta_start_ff [RING_FRAMES];
   logic [63:0] meta_end_ff [RING_FRAMES];
   logic [63:0] meta_block_ff [RING_FRAMES];

   logic [10:0]       n_eff;
   logic              out_free;
   logic              do_word, do_read, meta_we;
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [15:0]       ram_q;
   logic              last_rd;
   logic [31:0]       drop_now;
   logic [63:0]       end_t;

   // result held while the sample comes out of the store
   logic        p_last_ff, p_last_in;
   logic [63:0] p_start_ff, p_start_in, p_block_ff, p_block_in;
   logic [63:0] p_end_ff, p_end_in, p_bstart_ff, p_bstart_in;
   logic [3:0]  p_slot_ff, p_slot_in;
   logic [31:0] p_drop_ff, p_drop_in;

   logic        o_valid_ff, o_valid_in, o_load;
   logic [15:0] o_sample_ff, o_sample_in;
   logic        o_last_ff, o_last_in, o_ready_ff, o_ready_in;
   logic [63:0] o_start_ff, o_start_in, o_block_ff, o_block_in;
   logic [63:0] o_end_ff, o_end_in, o_bstart_ff, o_bstart_in;
   logic [3:0]  o_slot_ff, o_slot_in;
   logic [31:0] o_drop_ff, o_drop_in;

   i2sc_ram #(.WIDTH(PCM_BITS), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (head.sample),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      priority if (cfg.frame_samples == 11'd0) begin
         n_eff = 11'd1;
      end else if (cfg.frame_samples > 11'(FRAME_MAX)) begin
         n_eff = 11'(FRAME_MAX);
      end else begin
         n_eff = cfg.frame_samples;
      end
   end

   assign out_free = !o_valid_ff || rsp_ch.ready;
   assign ws_next  = (ws_ff == SLOT_W'(RING_FRAMES - 1)) ? '0 : ws_ff + 1'b1;
   assign rs_next  = (rs_ff == SLOT_W'(RING_FRAMES - 1)) ? '0 : rs_ff + 1'b1;
   assign do_word  = (state_ff == ST_IDLE) && head_valid && (head.cmd == CMD_WORD);
   assign do_read  = (state_ff == ST_IDLE) && head_valid && (head.cmd == CMD_READ) && out_free;
   assign pop      = do_word || do_read;

   assign wr_addr = ADDR_W'(ADDR_W'(ws_ff) * ADDR_W'(FRAME_MAX)) + ADDR_W'(wpos_ff >> 1);
   assign rd_addr = ADDR_W'(ADDR_W'(rs_ff) * ADDR_W'(FRAME_MAX)) + ADDR_W'(rpos_ff);
   assign ram_we  = do_word && (wpos_ff[0] == cfg.channel_select);
   assign ram_re  = do_read && (fr_ff != '0);
   assign meta_we = do_word && ({1'b0, wpos_ff} + 1'b1 >= {n_eff, 1'b0});
   assign last_rd = (12'(rpos_ff) + 12'd1 >= 12'(n_eff));
   assign drop_now = (rpos_ff == '0) ? drop_total_ff - drop_rep_ff : drop_lat_ff;
   assign end_t   = meta_end_ff[rs_ff];

   always_comb begin
      state_in      = state_ff;
      ws_in         = ws_ff;
      rs_in         = rs_ff;
      fr_in         = fr_ff;
      drop_total_in = drop_total_ff;
      drop_rep_in   = drop_rep_ff;
      drop_lat_in   = drop_lat_ff;
      next_start_in = next_start_ff;
      next_block_in = next_block_ff;
      wpos_in       = wpos_ff;
      rpos_in       = rpos_ff;
      p_last_in     = last_rd;
      p_start_in    = meta_start_ff[rs_ff];
      p_block_in    = meta_block_ff[rs_ff];
      p_end_in      = end_t;
      p_bstart_in   = (end_t >= 64'(cfg.frame_duration_us)) ?
                      end_t - 64'(cfg.frame_duration_us) : 64'd0;
      p_slot_in     = 4'(rs_ff);
      p_drop_in     = drop_now;
      o_load        = 1'b0;
      o_sample_in   = o_sample_ff;
      o_last_in     = o_last_ff;
      o_ready_in    = o_ready_ff;
      o_start_in    = o_start_ff;
      o_block_in    = o_block_ff;
      o_slot_in     = o_slot_ff;
      o_drop_in     = o_drop_ff;
      o_end_in      = o_end_ff;
      o_bstart_in   = o_bstart_ff;

      if (do_word) begin
         wpos_in = wpos_ff + 1'b1;
         if (meta_we) begin
            wpos_in       = '0;
            next_start_in = next_start_ff + 64'(n_eff);
            next_block_in = next_block_ff + 64'd1;
            ws_in         = ws_next;
            if (fr_ff == FR_W'(RING_FRAMES)) begin
               // ring full: oldest frame goes, partial read restarts
               rs_in         = rs_next;
               drop_total_in = drop_total_ff + 32'd1;
               rpos_in       = '0;
            end else begin
               fr_in = fr_ff + 1'b1;
            end
         end
      end

      if (do_read) begin
         if (fr_ff == '0) begin
            o_load      = 1'b1;
            o_sample_in = '0;
            o_last_in   = 1'b0;
            o_ready_in  = 1'b0;
            o_start_in  = '0;
            o_block_in  = '0;
            o_slot_in   = '0;
            o_drop_in   = '0;
            o_end_in    = '0;
            o_bstart_in = '0;
         end else begin
            state_in    = ST_WAIT;
            drop_lat_in = drop_now;
            if (rpos_ff == '0) begin
               drop_rep_in = drop_total_ff;
            end
            if (last_rd) begin
               rpos_in = '0;
               rs_in   = rs_next;
               fr_in   = fr_ff - 1'b1;
            end else begin
               rpos_in = rpos_ff + 1'b1;
            end
         end
      end

      if (state_ff == ST_WAIT && out_free) begin
         state_in    = ST_IDLE;
         o_load      = 1'b1;
         o_sample_in = ram_q;
         o_last_in   = p_last_ff;
         o_ready_in  = 1'b1;
         o_start_in  = p_start_ff;
         o_block_in  = p_block_ff;
         o_slot_in   = p_slot_ff;
         o_drop_in   = p_drop_ff;
         o_end_in    = p_end_ff;
         o_bstart_in = p_bstart_ff;
      end

      o_valid_in = o_load ? 1'b1 : (o_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ws_ff         <= '0;
         rs_ff         <= '0;
         fr_ff         <= '0;
         drop_total_ff <= '0;
         drop_rep_ff   <= '0;
         drop_lat_ff   <= '0;
         next_start_ff <= '0;
         next_block_ff <= '0;
         wpos_ff       <= '0;
         rpos_ff       <= '0;
         o_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ws_ff         <= ws_in;
         rs_ff         <= rs_in;
         fr_ff         <= fr_in;
         drop_total_ff <= drop_total_in;
         drop_rep_ff   <= drop_rep_in;
         drop_lat_ff   <= drop_lat_in;
         next_start_ff <= next_start_in;
         next_block_ff <= next_block_in;
         wpos_ff       <= wpos_in;
         rpos_ff       <= rpos_in;
         o_valid_ff    <= o_valid_in;
      end
      if (meta_we) begin
         meta_start_ff[ws_ff] <= next_start_ff;
         meta_end_ff[ws_ff]   <= head.now_us;
         meta_block_ff[ws_ff] <= next_block_ff + 64'd1;
      end
      if (ram_re) begin
         p_last_ff   <= p_last_in;
         p_start_ff  <= p_start_in;
         p_block_ff  <= p_block_in;
         p_end_ff    <= p_end_in;
         p_bstart_ff <= p_bstart_in;
         p_slot_ff   <= p_slot_in;
         p_drop_ff   <= p_drop_in;
      end
      o_sample_ff <= o_sample_in;
      o_last_ff   <= o_last_in;
      o_ready_ff  <= o_ready_in;
      o_start_ff  <= o_start_in;
      o_block_ff  <= o_block_in;
      o_slot_ff   <= o_slot_in;
      o_drop_ff   <= o_drop_in;
      o_end_ff    <= o_end_in;
      o_bstart_ff <= o_bstart_in;
   end

   assign rsp_ch.valid             = o_valid_ff;
   assign rsp_ch.sample            = o_sample_ff;
   assign rsp_ch.last_of_frame     = o_last_ff;
   assign rsp_ch.frame_ready       = o_ready_ff;
   assign rsp_ch.frame_start_index = o_start_ff;
   assign rsp_ch.block_count       = o_block_ff;
   assign rsp_ch.ring_slot         = o_slot_ff;
   assign rsp_ch.dropped_before    = o_drop_ff;
   assign rsp_ch.block_end_us      = o_end_ff;
   assign rsp_ch.block_start_us    = o_bstart_ff;
endmodule

@@ hdl/i2s_mono_frame_ring_capture_unit.sv @@
// channel  dir  transfer carries
// req_ch   in   cmd, raw_word, now_us
// rsp_ch   out  sample and frame metadata, one per read command
// csr_*    in   write enable, register index, data
//
// a slot word needs no wait state in the back end, a read with a frame ready passes
// the wait state (the sample store has a registered read port), a read with no frame none
// a two-entry queue sits between the decoder front end and the ring back end
// synchronous reset clears pointers and counters; the sample store is not cleared
// a stalled result holds in the output register while the queue keeps filling
module i2s_mono_frame_ring_capture_unit #(
   parameter int RING_FRAMES = i2sc_pkg::RING_FRAMES_DEFAULT,
   parameter int FRAME_MAX   = i2sc_pkg::FRAME_MAX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   i2sc_req_if.sink                             req_ch,
   i2sc_rsp_if.source                           rsp_ch,
   input  logic                                 csr_write,
   input  logic [i2sc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [i2sc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import i2sc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type head;
   logic     head_valid;
   logic     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CHANNEL_SELECT:    cfg_in.channel_select    = csr_data[0];
            CSR_WORD_BITS:         cfg_in.word_bits         = csr_data[5:0];
            CSR_CAPTURE_OFFSET:    cfg_in.capture_offset    = csr_data[5:0];
            CSR_FRAME_SAMPLES:     cfg_in.frame_samples     = csr_data[10:0];
            CSR_FRAME_DURATION_US: cfg_in.frame_duration_us = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_select    <= 1'b0;
         cfg_ff.word_bits         <= WORD_BITS_RESET;
         cfg_ff.capture_offset    <= '0;
         cfg_ff.frame_samples     <= FRAME_SAMPLES_RESET;
         cfg_ff.frame_duration_us <= FRAME_DURATION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2sc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   i2sc_back #(.RING_FRAMES(RING_FRAMES), .FRAME_MAX(FRAME_MAX)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );
endmodule
